>>> sv/bcp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcp_pkg : shared types and constants of the cascaded balance controller
// Register indexes, fixed-point widths, datapath command encoding.
// ----------------------------------------------------------------------------
package bcp_pkg;

  // drive saturation and loop limits
  localparam int PWM_LIMIT = 7200;
  localparam int INTEG_MAX = 10000;
  localparam int TILT_LIMIT = 1120;   // 70 degrees in 1/16 degree

  // divide by ten: q = (x * RECIP10) >> RECIP_SHIFT, then one correction step
  localparam int          RECIP_SHIFT = 24;
  localparam logic [20:0] RECIP10     = 21'd1677721;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 30;
  localparam int MUL_B_W = 22;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // configuration register indexes
  localparam logic [2:0] CFG_SPEED_REF  = 3'd0;
  localparam logic [2:0] CFG_MID_ANGLE  = 3'd1;
  localparam logic [2:0] CFG_YAW_REF    = 3'd2;
  localparam logic [2:0] CFG_UPRIGHT_P  = 3'd3;
  localparam logic [2:0] CFG_UPRIGHT_D  = 3'd4;
  localparam logic [2:0] CFG_SPEED_P    = 3'd5;
  localparam logic [2:0] CFG_SPEED_I    = 3'd6;
  localparam logic [2:0] CFG_TURN_KP    = 3'd7;

  localparam logic signed [12:0] MID_ANGLE_RESET = -13'sd160;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_DIV10,
    MUL_VKP_F,
    MUL_VKI_S,
    MUL_TKP_YAW,
    MUL_VKD_PRATE,
    MUL_VKP_DIFF
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_LOAD_SH4,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic     load;     // capture a new transaction
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     fix;      // finish divide, update filtered error
    logic     integ;    // update clamped integral
    logic     setp;     // capture turn term and pitch error
    logic     finish;   // form and register the drives
  } cmd_t;

endpackage
`default_nettype wire

>>> sv/bcp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcp_datapath : registers, shared multiplier and accumulator
// Holds configuration and loop state; executes one controller command a cycle.
// ----------------------------------------------------------------------------
module bcp_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [15:0]         cfg_data,
  input  wire logic signed [15:0]  left_speed,
  input  wire logic signed [15:0]  right_speed,
  input  wire logic signed [12:0]  pitch,
  input  wire logic signed [15:0]  pitch_rate,
  input  wire logic signed [15:0]  yaw_rate,
  input  wire bcp_pkg::cmd_t       cmd,
  output logic signed [13:0]       left_drive,
  output logic signed [13:0]       right_drive,
  output logic                     brake_on
);

  // configuration
  logic signed [15:0] speed_ref, yaw_ref;
  logic signed [12:0] mid_angle;
  logic signed [15:0] upright_p, upright_d, speed_p, speed_i, turn_kp;

  // loop state
  logic signed [17:0] filt_err;
  logic signed [14:0] speed_int;

  // per-transaction registers
  logic [19:0]        abs_x;
  logic               x_neg;
  logic signed [12:0] pitch_r;
  logic signed [15:0] prate_r;
  logic signed [15:0] yaw_r;
  logic signed [bcp_pkg::PROD_W-1:0] prod;
  logic signed [bcp_pkg::PROD_W-1:0] acc;
  logic signed [25:0] turn;
  logic signed [29:0] diff;

  // load: speed error and filter numerator
  logic signed [17:0] speed_err;
  logic signed [20:0] x_num;
  always_comb begin
    speed_err = 18'(left_speed) - 18'(right_speed) - 18'(speed_ref);
    x_num     = 21'(speed_err) * 21'sd3 + 21'(filt_err) * 21'sd7;
  end

  // shared multiplier
  logic signed [bcp_pkg::MUL_A_W-1:0] mul_a;
  logic signed [bcp_pkg::MUL_B_W-1:0] mul_b;
  logic signed [16:0]                 yaw_err;
  always_comb begin
    yaw_err = 17'(yaw_r) - 17'(yaw_ref);
    unique case (cmd.mul_sel)
      bcp_pkg::MUL_DIV10: begin
        mul_a = $signed({10'b0, abs_x});
        mul_b = $signed({1'b0, bcp_pkg::RECIP10});
      end
      bcp_pkg::MUL_VKP_F: begin
        mul_a = 30'(filt_err);
        mul_b = 22'(speed_p);
      end
      bcp_pkg::MUL_VKI_S: begin
        mul_a = 30'(speed_int);
        mul_b = 22'(speed_i);
      end
      bcp_pkg::MUL_TKP_YAW: begin
        mul_a = 30'(yaw_err);
        mul_b = 22'(turn_kp);
      end
      bcp_pkg::MUL_VKD_PRATE: begin
        mul_a = 30'(prate_r);
        mul_b = 22'(upright_d);
      end
      bcp_pkg::MUL_VKP_DIFF: begin
        mul_a = diff;
        mul_b = 22'(upright_p);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divide correction: quotient estimate is exact or one short
  logic [16:0]        q_est;
  logic [20:0]        ten_q;
  logic [20:0]        rem;
  logic [17:0]        q_fix;
  logic signed [17:0] filt_next;
  always_comb begin
    q_est     = prod[40:24];
    ten_q     = 21'({q_est, 3'b0}) + 21'({q_est, 1'b0});
    rem       = 21'(abs_x) - ten_q;
    q_fix     = 18'(q_est) + 18'(rem >= 21'd10);
    filt_next = x_neg ? -$signed(q_fix) : $signed(q_fix);
  end

  // integral with clamp
  logic signed [17:0] int_sum;
  logic signed [14:0] int_next;
  always_comb begin
    int_sum = 18'(speed_int) + filt_err;
    if (int_sum > 18'(bcp_pkg::INTEG_MAX)) begin
      int_next = 15'(bcp_pkg::INTEG_MAX);
    end else if (int_sum < -18'(bcp_pkg::INTEG_MAX)) begin
      int_next = -15'(bcp_pkg::INTEG_MAX);
    end else begin
      int_next = int_sum[14:0];
    end
  end

  // velocity output to setpoint, turn term; both truncate toward zero
  logic signed [bcp_pkg::PROD_W-1:0] acc_adj, prod_adj, vel_full, turn_full;
  logic signed [25:0] vel;
  logic signed [29:0] diff_next;
  always_comb begin
    acc_adj   = acc + (acc[bcp_pkg::PROD_W-1] ? 52'sd255 : 52'sd0);
    vel_full  = acc_adj >>> 8;
    vel       = vel_full[25:0];
    diff_next = 30'(pitch_r) - 30'(mid_angle) - $signed({vel, 4'b0});
    prod_adj  = prod + (prod[bcp_pkg::PROD_W-1] ? 52'sd255 : 52'sd0);
    turn_full = prod_adj >>> 8;
  end

  // upright term and saturation
  logic signed [bcp_pkg::PROD_W-1:0] vert_adj, vert_full;
  logic signed [33:0] vert;
  logic signed [34:0] l_sum, r_sum;
  logic signed [15:0] l_sat, r_sat;
  logic               tilt;
  always_comb begin
    vert_adj  = acc + (acc[bcp_pkg::PROD_W-1] ? 52'sd4095 : 52'sd0);
    vert_full = vert_adj >>> 12;
    vert      = vert_full[33:0];
    l_sum     = 35'(vert) + 35'(turn);
    r_sum     = 35'(vert) - 35'(turn);
    if (l_sum > 35'(bcp_pkg::PWM_LIMIT)) begin
      l_sat = 16'(bcp_pkg::PWM_LIMIT);
    end else if (l_sum < -35'(bcp_pkg::PWM_LIMIT)) begin
      l_sat = -16'(bcp_pkg::PWM_LIMIT);
    end else begin
      l_sat = l_sum[15:0];
    end
    if (r_sum > 35'(bcp_pkg::PWM_LIMIT)) begin
      r_sat = 16'(bcp_pkg::PWM_LIMIT);
    end else if (r_sum < -35'(bcp_pkg::PWM_LIMIT)) begin
      r_sat = -16'(bcp_pkg::PWM_LIMIT);
    end else begin
      r_sat = r_sum[15:0];
    end
    tilt = (pitch_r >= 13'(bcp_pkg::TILT_LIMIT)) || (pitch_r <= -13'(bcp_pkg::TILT_LIMIT));
  end

  // configuration and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_ref    <= '0;
      mid_angle    <= bcp_pkg::MID_ANGLE_RESET;
      yaw_ref      <= '0;
      upright_p    <= '0;
      upright_d    <= '0;
      speed_p      <= '0;
      speed_i      <= '0;
      turn_kp      <= '0;
      filt_err     <= '0;
      speed_int    <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          bcp_pkg::CFG_SPEED_REF:  speed_ref    <= $signed(cfg_data);
          bcp_pkg::CFG_MID_ANGLE:  mid_angle    <= $signed(cfg_data[12:0]);
          bcp_pkg::CFG_YAW_REF:    yaw_ref      <= $signed(cfg_data);
          bcp_pkg::CFG_UPRIGHT_P:  upright_p    <= $signed(cfg_data);
          bcp_pkg::CFG_UPRIGHT_D:  upright_d    <= $signed(cfg_data);
          bcp_pkg::CFG_SPEED_P:    speed_p      <= $signed(cfg_data);
          bcp_pkg::CFG_SPEED_I:    speed_i      <= $signed(cfg_data);
          bcp_pkg::CFG_TURN_KP:    turn_kp      <= $signed(cfg_data);
          default: ;
        endcase
      end
      if (cmd.fix) begin
        filt_err <= filt_next;
      end
      if (cmd.integ) begin
        speed_int <= int_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_neg   <= x_num[20];
      abs_x   <= x_num[20] ? 20'(-x_num) : x_num[19:0];
      pitch_r <= pitch;
      prate_r <= pitch_rate;
      yaw_r   <= yaw_rate;
    end
    if (cmd.mul_sel != bcp_pkg::MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
    unique case (cmd.acc_op)
      bcp_pkg::ACC_LOAD:     acc <= prod;
      bcp_pkg::ACC_LOAD_SH4: acc <= prod <<< 4;
      bcp_pkg::ACC_ADD:      acc <= acc + prod;
      default:               ;
    endcase
    if (cmd.setp) begin
      diff <= diff_next;
      turn <= turn_full[25:0];
    end
    if (cmd.finish) begin
      left_drive  <= tilt ? 14'sd0 : l_sat[13:0];
      right_drive <= tilt ? 14'sd0 : r_sat[13:0];
      brake_on    <= tilt;
    end
  end

endmodule
`default_nettype wire

>>> sv/bcp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcp_ctrl : sequencer of the cascaded balance controller
// Steps the datapath through one control tick and owns both handshakes.
// ----------------------------------------------------------------------------
module bcp_ctrl (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output bcp_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    IDLE,
    DIV,
    FIX,
    INTEG,
    VEL1,
    VEL2,
    VEL3,
    VERT1,
    VERT2,
    FINISH
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    cmd.load   = in_valid && in_ready;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          state_next = DIV;
        end
      end
      DIV: begin
        cmd.mul_sel = bcp_pkg::MUL_DIV10;
        state_next  = FIX;
      end
      FIX: begin
        cmd.fix    = 1'b1;
        state_next = INTEG;
      end
      INTEG: begin
        cmd.integ   = 1'b1;
        cmd.mul_sel = bcp_pkg::MUL_VKP_F;
        state_next  = VEL1;
      end
      VEL1: begin
        cmd.acc_op  = bcp_pkg::ACC_LOAD;
        cmd.mul_sel = bcp_pkg::MUL_VKI_S;
        state_next  = VEL2;
      end
      VEL2: begin
        cmd.acc_op  = bcp_pkg::ACC_ADD;
        cmd.mul_sel = bcp_pkg::MUL_TKP_YAW;
        state_next  = VEL3;
      end
      VEL3: begin
        cmd.setp    = 1'b1;
        cmd.mul_sel = bcp_pkg::MUL_VKD_PRATE;
        state_next  = VERT1;
      end
      VERT1: begin
        cmd.acc_op  = bcp_pkg::ACC_LOAD_SH4;
        cmd.mul_sel = bcp_pkg::MUL_VKP_DIFF;
        state_next  = VERT2;
      end
      VERT2: begin
        cmd.acc_op = bcp_pkg::ACC_ADD;
        state_next = FINISH;
      end
      FINISH: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/balance_cascade_pid_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// balance_cascade_pid_unit : cascaded PI / PD / P controller, two-wheel robot
// One control tick in, one pair of saturated drives and a brake flag out.
// ----------------------------------------------------------------------------
//  channel   signals                                   handshake
//  ------    ----------------------------------------  -------------------
//  cfg       cfg_index, cfg_data                       cfg_write, no wait
//  in        left_speed right_speed pitch pitch_rate   in_valid / in_ready
//            yaw_rate
//  out       left_drive right_drive brake_on           out_valid / out_ready
//
//  A transaction steps the sequencer through DIV, FIX, INTEG, VEL1 to VEL3,
//  VERT1, VERT2 and FINISH; one shared multiplier takes six products in turn.
//  One transaction is in work at a time; in_ready is high while idle, even
//  while a finished result waits in the output register.
//  A stalled output holds the sequencer in its last step only.
//  Synchronous reset clears the loop state and loads register defaults.
// ----------------------------------------------------------------------------
module balance_cascade_pid_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] left_speed,
  input  wire logic signed [15:0] right_speed,
  input  wire logic signed [12:0] pitch,
  input  wire logic signed [15:0] pitch_rate,
  input  wire logic signed [15:0] yaw_rate,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [13:0]      left_drive,
  output logic signed [13:0]      right_drive,
  output logic                    brake_on
);

  bcp_pkg::cmd_t cmd;

  bcp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bcp_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .left_speed  (left_speed),
    .right_speed (right_speed),
    .pitch       (pitch),
    .pitch_rate  (pitch_rate),
    .yaw_rate    (yaw_rate),
    .cmd         (cmd),
    .left_drive  (left_drive),
    .right_drive (right_drive),
    .brake_on    (brake_on)
  );

  // busy after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // a new result only appears as the sequencer finishes a tick
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised without a tick in work");

  // braked ticks carry zero drive
  a_brake_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && brake_on |-> left_drive == 14'sd0 && right_drive == 14'sd0)
    else $error("drive present while braked");

  // left drive stays within the limit
  a_drive_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bcp_pkg::PWM_LIMIT > 8191) ||
      ($signed(left_drive) <= bcp_pkg::PWM_LIMIT &&
       $signed(left_drive) >= -bcp_pkg::PWM_LIMIT))
    else $error("left drive beyond limit");

endmodule
`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench : cascaded balance controller, two-wheel robot
// Streams control ticks through balance_cascade_pid_unit under a range of
// gain settings and handshake pressure. Each drive pair and brake flag is
// checked against an untimed model of the velocity, upright and turn loops.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int TICKS_PER_SET = 120;

  typedef struct {
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic signed [12:0] pitch;
    logic signed [15:0] pitch_rate;
    logic signed [15:0] yaw_rate;
  } tick_t;

  typedef struct {
    logic signed [13:0] left_drive;
    logic signed [13:0] right_drive;
    logic               brake_on;
  } drive_t;

  typedef struct {
    logic signed [15:0] speed_ref;
    logic signed [12:0] mid_angle;
    logic signed [15:0] yaw_ref;
    logic signed [15:0] upright_p;
    logic signed [15:0] upright_d;
    logic signed [15:0] speed_p;
    logic signed [15:0] speed_i;
    logic signed [15:0] turn_kp;
  } gains_t;

  typedef enum int {
    SET_EXTREME,
    SET_MODERATE,
    SET_RAW
  } setting_kind_t;

  typedef logic [15:0] reg_words_t [8];

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               cfg_write   = 1'b0;
  logic [2:0]         cfg_index   = '0;
  logic [15:0]        cfg_data    = '0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic signed [15:0] left_speed  = '0;
  logic signed [15:0] right_speed = '0;
  logic signed [12:0] pitch       = '0;
  logic signed [15:0] pitch_rate  = '0;
  logic signed [15:0] yaw_rate    = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic signed [13:0] left_drive;
  logic signed [13:0] right_drive;
  logic               brake_on;

  gains_t gains;
  longint filt_err       = 0;
  longint speed_integ    = 0;
  drive_t pending_drives [$];
  int     mismatch_count = 0;
  int     cycle_count    = 0;
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;

  balance_cascade_pid_unit dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model --

  function automatic longint clamp_drive(longint v);
    if (v > bcp_pkg::PWM_LIMIT) return bcp_pkg::PWM_LIMIT;
    if (v < -bcp_pkg::PWM_LIMIT) return -bcp_pkg::PWM_LIMIT;
    return v;
  endfunction

  // advance the loop state by one tick and return the drives it produces
  function automatic drive_t predict_drive(tick_t t);
    drive_t d;
    longint err, vel, setp, vert, turn, l, r, tilt;
    err = longint'(t.left_speed) - longint'(t.right_speed)
        - longint'(gains.speed_ref);
    filt_err = (3 * err + 7 * filt_err) / 10;
    speed_integ = speed_integ + filt_err;
    if (speed_integ > bcp_pkg::INTEG_MAX) speed_integ = bcp_pkg::INTEG_MAX;
    if (speed_integ < -bcp_pkg::INTEG_MAX) speed_integ = -bcp_pkg::INTEG_MAX;
    vel = (longint'(gains.speed_p) * filt_err
         + longint'(gains.speed_i) * speed_integ) / 256;
    setp = longint'(gains.mid_angle) + 16 * vel;
    vert = (longint'(gains.upright_p) * (longint'(t.pitch) - setp)
          + 16 * longint'(gains.upright_d) * longint'(t.pitch_rate)) / 4096;
    turn = (longint'(gains.turn_kp)
          * (longint'(t.yaw_rate) - longint'(gains.yaw_ref))) / 256;
    l = clamp_drive(vert + turn);
    r = clamp_drive(vert - turn);
    tilt = (t.pitch < 0) ? -longint'(t.pitch) : longint'(t.pitch);
    d.brake_on = (tilt >= bcp_pkg::TILT_LIMIT);
    if (d.brake_on) begin
      l = 0;
      r = 0;
    end
    d.left_drive  = l[13:0];
    d.right_drive = r[13:0];
    return d;
  endfunction

  // ------------------------------------------------------------- drivers --

  // hold cfg_write high; the caller drops it after the last write
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      bcp_pkg::CFG_SPEED_REF: gains.speed_ref = data;
      bcp_pkg::CFG_MID_ANGLE: gains.mid_angle = data[12:0];
      bcp_pkg::CFG_YAW_REF:   gains.yaw_ref   = data;
      bcp_pkg::CFG_UPRIGHT_P: gains.upright_p = data;
      bcp_pkg::CFG_UPRIGHT_D: gains.upright_d = data;
      bcp_pkg::CFG_SPEED_P:   gains.speed_p   = data;
      bcp_pkg::CFG_SPEED_I:   gains.speed_i   = data;
      bcp_pkg::CFG_TURN_KP:   gains.turn_kp   = data;
      default: ;
    endcase
  endtask

  task automatic program_gains(input reg_words_t words);
    for (int i = 0; i < 8; i++) begin
      write_reg(3'(i), words[i]);
    end
    cfg_write <= 1'b0;
  endtask

  // leave in_valid high on return so a following tick can go straight out
  task automatic send_tick(input tick_t t);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    left_speed  <= t.left_speed;
    right_speed <= t.right_speed;
    pitch       <= t.pitch;
    pitch_rate  <= t.pitch_rate;
    yaw_rate    <= t.yaw_rate;
    do @(posedge clk); while (!in_ready);
    pending_drives.push_back(predict_drive(t));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic tick_t make_tick(int ls, int rs, int p, int pr, int yr);
    tick_t t;
    t.left_speed  = 16'(ls);
    t.right_speed = 16'(rs);
    t.pitch       = 13'(p);
    t.pitch_rate  = 16'(pr);
    t.yaw_rate    = 16'(yr);
    return t;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    int    mag;
    if ($urandom_range(9) == 0) begin
      t.left_speed  = 16'($urandom);
      t.right_speed = 16'($urandom);
      t.pitch       = 13'($urandom);
      t.pitch_rate  = 16'($urandom);
      t.yaw_rate    = 16'($urandom);
    end else begin
      t.left_speed  = 16'(int'($urandom_range(600)) - 300);
      t.right_speed = 16'(int'($urandom_range(600)) - 300);
      if ($urandom_range(3) == 0) begin
        // straddle the tilt cut-off
        mag = int'($urandom_range(8)) + bcp_pkg::TILT_LIMIT - 4;
        t.pitch = 13'($urandom_range(1) ? mag : -mag);
      end else begin
        t.pitch = 13'(int'($urandom_range(2400)) - 1200);
      end
      t.pitch_rate = 16'(int'($urandom_range(4000)) - 2000);
      t.yaw_rate   = 16'(int'($urandom_range(4000)) - 2000);
    end
    return t;
  endfunction

  function automatic logic [15:0] rand_reg_word(logic [2:0] idx, setting_kind_t kind);
    logic [15:0] w;
    case (kind)
      SET_EXTREME: begin
        case ($urandom_range(2))
          0:       w = 16'h7FFF;
          1:       w = 16'h8000;
          default: w = 16'h0000;
        endcase
        if (idx == bcp_pkg::CFG_MID_ANGLE) begin
          w = $urandom_range(1) ? 16'(2880) : 16'(-2880);
        end
      end
      SET_MODERATE: begin
        case (idx)
          bcp_pkg::CFG_SPEED_REF: w = 16'(int'($urandom_range(200)) - 100);
          bcp_pkg::CFG_MID_ANGLE: w = 16'(int'($urandom_range(800)) - 400);
          bcp_pkg::CFG_YAW_REF:   w = 16'(int'($urandom_range(1000)) - 500);
          default:                w = 16'(int'($urandom_range(2048)) - 1024);
        endcase
      end
      default: w = 16'($urandom);
    endcase
    return w;
  endfunction

  // ------------------------------------------------------------ checking --

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_drive
    drive_t exp_d;
    if (!rst && out_valid && out_ready) begin
      if (pending_drives.size() == 0) begin
        $display("%0t: unexpected transaction left_drive %0d right_drive %0d brake_on %0d",
                 $time, left_drive, right_drive, brake_on);
        mismatch_count++;
      end else begin
        exp_d = pending_drives.pop_front();
        if (left_drive !== exp_d.left_drive) begin
          $display("%0t: left_drive expected %0d actual %0d",
                   $time, exp_d.left_drive, left_drive);
          mismatch_count++;
        end
        if (right_drive !== exp_d.right_drive) begin
          $display("%0t: right_drive expected %0d actual %0d",
                   $time, exp_d.right_drive, right_drive);
          mismatch_count++;
        end
        if (brake_on !== exp_d.brake_on) begin
          $display("%0t: brake_on expected %0d actual %0d",
                   $time, exp_d.brake_on, brake_on);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------- tests --

  // register defaults: zero gains, brake edges, then mid angle left at reset
  task automatic test_reset_defaults();
    send_tick(make_tick(100, -50, 1119, 0, 0));
    send_tick(make_tick(-100, 50, bcp_pkg::TILT_LIMIT, 300, -300));
    send_tick(make_tick(0, 0, -1119, 0, 0));
    send_tick(make_tick(0, 0, -bcp_pkg::TILT_LIMIT, 0, 0));
    send_tick(make_tick(0, 0, 4095, 0, 0));
    send_tick(make_tick(0, 0, -4096, 0, 0));
    wait_for_results();
    write_reg(bcp_pkg::CFG_UPRIGHT_P, 16'h0400);
    cfg_write <= 1'b0;
    send_tick(make_tick(0, 0, 0, 0, 0));
    send_tick(make_tick(0, 0, -320, 0, 0));
    wait_for_results();
  endtask

  // saturated speeds drive the integral into its clamp both ways, then full-scale gains of either sign
  task automatic test_directed_extremes();
    reg_words_t w;
    w[bcp_pkg::CFG_SPEED_REF] = 16'h0000;
    w[bcp_pkg::CFG_MID_ANGLE] = 16'hFF60;
    w[bcp_pkg::CFG_YAW_REF]   = 16'h0000;
    w[bcp_pkg::CFG_UPRIGHT_P] = 16'h0400;
    w[bcp_pkg::CFG_UPRIGHT_D] = 16'h0010;
    w[bcp_pkg::CFG_SPEED_P]   = 16'h0100;
    w[bcp_pkg::CFG_SPEED_I]   = 16'h0010;
    w[bcp_pkg::CFG_TURN_KP]   = 16'h0200;
    program_gains(w);
    repeat (4) send_tick(make_tick(32767, -32768, 0, 0, 0));
    repeat (4) send_tick(make_tick(-32768, 32767, 0, 0, 0));
    send_tick(make_tick(0, 0, 100, 32767, -32768));
    send_tick(make_tick(0, 0, -100, -32768, 32767));
    wait_for_results();

    w[bcp_pkg::CFG_SPEED_REF] = 16'h7FFF;
    w[bcp_pkg::CFG_MID_ANGLE] = 16'(2880);
    w[bcp_pkg::CFG_YAW_REF]   = 16'h7FFF;
    w[bcp_pkg::CFG_UPRIGHT_P] = 16'h7FFF;
    w[bcp_pkg::CFG_UPRIGHT_D] = 16'h7FFF;
    w[bcp_pkg::CFG_SPEED_P]   = 16'h7FFF;
    w[bcp_pkg::CFG_SPEED_I]   = 16'h7FFF;
    w[bcp_pkg::CFG_TURN_KP]   = 16'h7FFF;
    program_gains(w);
    send_tick(make_tick(32767, -32768, 2880, 32767, 32767));
    send_tick(make_tick(-32768, 32767, -2880, -32768, -32768));
    wait_for_results();

    w[bcp_pkg::CFG_SPEED_REF] = 16'h8000;
    w[bcp_pkg::CFG_MID_ANGLE] = 16'(-2880);
    w[bcp_pkg::CFG_YAW_REF]   = 16'h8000;
    w[bcp_pkg::CFG_UPRIGHT_P] = 16'h8000;
    w[bcp_pkg::CFG_UPRIGHT_D] = 16'h8000;
    w[bcp_pkg::CFG_SPEED_P]   = 16'h8000;
    w[bcp_pkg::CFG_SPEED_I]   = 16'h8000;
    w[bcp_pkg::CFG_TURN_KP]   = 16'h8000;
    program_gains(w);
    // largest speed error the fields allow
    send_tick(make_tick(32767, -32768, 1000, -32768, 32767));
    send_tick(make_tick(32767, -32768, -1000, 32767, -32768));
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    setting_kind_t plan [4];
    reg_words_t    w;
    plan = '{SET_EXTREME, SET_MODERATE, SET_RAW, SET_MODERATE};
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    foreach (plan[s]) begin
      for (int i = 0; i < 8; i++) w[i] = rand_reg_word(3'(i), plan[s]);
      program_gains(w);
      repeat (TICKS_PER_SET) send_tick(random_tick());
      wait_for_results();
    end
  endtask

  initial begin
    gains.speed_ref = '0;
    gains.mid_angle = bcp_pkg::MID_ANGLE_RESET;
    gains.yaw_ref   = '0;
    gains.upright_p = '0;
    gains.upright_d = '0;
    gains.speed_p   = '0;
    gains.speed_i   = '0;
    gains.turn_kp   = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_directed_extremes();
    test_random_traffic(0, 0);
    test_random_traffic(83, 0);
    test_random_traffic(0, 83);
    test_random_traffic(11, 11);

    wait_for_results();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> balance_cascade_pid_unit.f
sv/bcp_pkg.sv
sv/bcp_datapath.sv
sv/bcp_ctrl.sv
sv/balance_cascade_pid_unit.sv
dv/testbench.sv
